### sv/dwes_pkg.sv
// shared constants, codes and control types for the dual wheel encoder speed block
`timescale 1ns / 1ps

package dwes_pkg;

  localparam int NOTCH_W     = 16;
  localparam int TIMEOUT_W   = 32;
  localparam int TIME_W      = 64;
  localparam int COUNT_W     = 32;
  localparam int DIST_W      = 48;
  localparam int SPEED_OUT_W = 24;
  localparam int USPS_W      = 20;
  localparam int DIVIDEND_W  = NOTCH_W + USPS_W;
  localparam int DIVISOR_W   = TIMEOUT_W;
  localparam int DIV_CNT_W   = $clog2(DIVIDEND_W + 1);
  localparam int CFG_DATA_W  = TIMEOUT_W;

  localparam logic [USPS_W-1:0]    US_PER_S      = USPS_W'(1000000);
  localparam logic [NOTCH_W-1:0]   NOTCH_RST     = NOTCH_W'(269);
  localparam logic [TIMEOUT_W-1:0] TIMEOUT_RST   = TIMEOUT_W'(1500000);

  // request codes
  localparam logic [1:0] REQ_NOTCH = 2'd0;
  localparam logic [1:0] REQ_CHECK = 2'd1;
  localparam logic [1:0] REQ_CLEAR = 2'd2;

  // configuration register indexes
  localparam logic CFG_NOTCH_SIZE = 1'b0;
  localparam logic CFG_TIMEOUT    = 1'b1;

  typedef struct packed {
    logic load;       // capture the accepted item
    logic calc;       // form intervals and notch product
    logic div_start;  // launch speed division
    logic apply;      // update state without a divided speed value
    logic apply_div;  // update state with the divided speed
    logic dist_go;    // form distances for the result
  } dwes_cmd_t;

  typedef struct packed {
    logic notch_ok;
    logic div_done;
  } dwes_sts_t;

endpackage

### sv/dwes_div.sv
// radix-2 restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps

module dwes_div
  import dwes_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic [DIVIDEND_W-1:0] dividend,
  input  logic [DIVISOR_W-1:0]  divisor,
  output logic                  done,
  output logic [DIVIDEND_W-1:0] quotient
);

  logic                  busy_r;
  logic                  done_r;
  logic [DIV_CNT_W-1:0]  cnt_r;
  logic [DIVISOR_W:0]    rem_r;
  logic [DIVIDEND_W-1:0] quo_r;
  logic [DIVISOR_W-1:0]  dvs_r;

  logic [DIVISOR_W:0]    rem_sh;
  logic [DIVISOR_W:0]    rem_diff;
  logic                  ge;

  always_comb begin
    rem_sh   = {rem_r[DIVISOR_W-1:0], quo_r[DIVIDEND_W-1]};
    rem_diff = rem_sh - {1'b0, dvs_r};
    ge       = (rem_sh >= {1'b0, dvs_r});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= DIV_CNT_W'(DIVIDEND_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - DIV_CNT_W'(1);
        if (cnt_r == DIV_CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // dividend bits shift out of quo_r as quotient bits shift in
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= dividend;
      dvs_r <= divisor;
    end else if (busy_r) begin
      rem_r <= ge ? rem_diff : rem_sh;
      quo_r <= {quo_r[DIVIDEND_W-2:0], ge};
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

### sv/dwes_dp.sv
// datapath: configuration, wheel state, interval math, speed and distance
`timescale 1ns / 1ps

module dwes_dp
  import dwes_pkg::*;
#(
  parameter int SPEED_WIDTH = 24
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  dwes_cmd_t              cmd,
  output dwes_sts_t              sts,
  input  logic                   cfg_we,
  input  logic                   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata,
  input  logic [1:0]             in_req_type,
  input  logic                   in_wheel,
  input  logic [TIME_W-1:0]      in_timestamp_us,
  output logic [COUNT_W-1:0]     out_left_count,
  output logic [COUNT_W-1:0]     out_right_count,
  output logic [DIST_W-1:0]      out_left_distance_q8,
  output logic [DIST_W-1:0]      out_right_distance_q8,
  output logic [SPEED_OUT_W-1:0] out_left_speed_q8,
  output logic [SPEED_OUT_W-1:0] out_right_speed_q8
);

  localparam int SAT_W = (SPEED_WIDTH > DIVIDEND_W) ? SPEED_WIDTH : DIVIDEND_W;
  localparam int EXT_W = (SPEED_WIDTH > SPEED_OUT_W) ? SPEED_WIDTH : SPEED_OUT_W;

  logic [NOTCH_W-1:0]     notch_r;
  logic [TIMEOUT_W-1:0]   timeout_r;

  logic [1:0]             req_r;
  logic                   wheel_r;
  logic [TIME_W-1:0]      now_r;

  logic [COUNT_W-1:0]     left_cnt_r;
  logic [COUNT_W-1:0]     right_cnt_r;
  logic [TIME_W-1:0]      left_last_r;
  logic [TIME_W-1:0]      right_last_r;
  logic [SPEED_WIDTH-1:0] left_spd_r;
  logic [SPEED_WIDTH-1:0] right_spd_r;

  logic [TIME_W-1:0]      dt_r;
  logic [TIME_W-1:0]      left_idle_r;
  logic [TIME_W-1:0]      right_idle_r;
  logic [DIVIDEND_W-1:0]  prod_r;
  logic [DIST_W-1:0]      left_dist_r;
  logic [DIST_W-1:0]      right_dist_r;

  logic                   div_done;
  logic [DIVIDEND_W-1:0]  quotient;
  logic [SAT_W-1:0]       q_ext;
  logic [SAT_W-1:0]       spd_max;
  logic [SPEED_WIDTH-1:0] spd_sat;
  logic [EXT_W-1:0]       left_spd_ext;
  logic [EXT_W-1:0]       right_spd_ext;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      notch_r   <= NOTCH_RST;
      timeout_r <= TIMEOUT_RST;
    end else if (cfg_we) begin
      if (cfg_index == CFG_NOTCH_SIZE) begin
        notch_r <= cfg_wdata[NOTCH_W-1:0];
      end else begin
        timeout_r <= cfg_wdata[TIMEOUT_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_r   <= in_req_type;
      wheel_r <= in_wheel;
      now_r   <= in_timestamp_us;
    end
    if (cmd.calc) begin
      dt_r         <= now_r - (wheel_r ? right_last_r : left_last_r);
      left_idle_r  <= now_r - left_last_r;
      right_idle_r <= now_r - right_last_r;
      prod_r       <= DIVIDEND_W'(notch_r) * DIVIDEND_W'(US_PER_S);
    end
    if (cmd.dist_go) begin
      left_dist_r  <= DIST_W'(left_cnt_r) * DIST_W'(notch_r);
      right_dist_r <= DIST_W'(right_cnt_r) * DIST_W'(notch_r);
    end
  end

  assign sts.notch_ok = (req_r == REQ_NOTCH) && (dt_r != '0) &&
                        (dt_r < TIME_W'(timeout_r));
  assign sts.div_done = div_done;

  dwes_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (prod_r),
    .divisor  (dt_r[DIVISOR_W-1:0]),
    .done     (div_done),
    .quotient (quotient)
  );

  always_comb begin
    q_ext   = SAT_W'(quotient);
    spd_max = SAT_W'({SPEED_WIDTH{1'b1}});
    spd_sat = (q_ext > spd_max) ? {SPEED_WIDTH{1'b1}} : q_ext[SPEED_WIDTH-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_cnt_r   <= '0;
      right_cnt_r  <= '0;
      left_last_r  <= '0;
      right_last_r <= '0;
      left_spd_r   <= '0;
      right_spd_r  <= '0;
    end else if (cmd.apply_div) begin
      if (wheel_r) begin
        right_cnt_r  <= right_cnt_r + COUNT_W'(1);
        right_spd_r  <= spd_sat;
        right_last_r <= now_r;
      end else begin
        left_cnt_r  <= left_cnt_r + COUNT_W'(1);
        left_spd_r  <= spd_sat;
        left_last_r <= now_r;
      end
    end else if (cmd.apply) begin
      case (req_r)
        REQ_NOTCH: begin
          // zero or out-of-range interval: wheel treated as stopped
          if (wheel_r) begin
            right_spd_r  <= '0;
            right_last_r <= now_r;
          end else begin
            left_spd_r  <= '0;
            left_last_r <= now_r;
          end
        end
        REQ_CHECK: begin
          if (left_idle_r > TIME_W'(timeout_r)) begin
            left_spd_r <= '0;
          end
          if (right_idle_r > TIME_W'(timeout_r)) begin
            right_spd_r <= '0;
          end
        end
        REQ_CLEAR: begin
          left_cnt_r   <= '0;
          right_cnt_r  <= '0;
          left_last_r  <= now_r;
          right_last_r <= now_r;
        end
        default: begin
        end
      endcase
    end
  end

  assign left_spd_ext  = EXT_W'(left_spd_r);
  assign right_spd_ext = EXT_W'(right_spd_r);

  assign out_left_count        = left_cnt_r;
  assign out_right_count       = right_cnt_r;
  assign out_left_distance_q8  = left_dist_r;
  assign out_right_distance_q8 = right_dist_r;
  assign out_left_speed_q8     = left_spd_ext[SPEED_OUT_W-1:0];
  assign out_right_speed_q8    = right_spd_ext[SPEED_OUT_W-1:0];

endmodule

### sv/dwes_ctrl.sv
// controller: sequences one item through calc, divide (counted notches only), distance and output
`timescale 1ns / 1ps

module dwes_ctrl
  import dwes_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  logic      out_ready,
  input  dwes_sts_t sts,
  output dwes_cmd_t cmd
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CALC,
    ST_CMP,
    ST_DIV,
    ST_DIST,
    ST_OUT
  } state_t;

  state_t state_r;
  logic   in_ready_r;
  logic   out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      in_ready_r  <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      case (state_r)
        ST_IDLE: begin
          if (in_valid && in_ready_r) begin
            in_ready_r <= 1'b0;
            state_r    <= ST_CALC;
          end
        end
        ST_CALC: begin
          state_r <= ST_CMP;
        end
        ST_CMP: begin
          state_r <= sts.notch_ok ? ST_DIV : ST_DIST;
        end
        ST_DIV: begin
          if (sts.div_done) begin
            state_r <= ST_DIST;
          end
        end
        ST_DIST: begin
          out_valid_r <= 1'b1;
          state_r     <= ST_OUT;
        end
        ST_OUT: begin
          if (out_ready) begin
            out_valid_r <= 1'b0;
            in_ready_r  <= 1'b1;
            state_r     <= ST_IDLE;
          end
        end
        default: begin
          state_r     <= ST_IDLE;
          in_ready_r  <= 1'b1;
          out_valid_r <= 1'b0;
        end
      endcase
    end
  end

  always_comb begin
    cmd           = '0;
    cmd.load      = (state_r == ST_IDLE) && in_valid && in_ready_r;
    cmd.calc      = (state_r == ST_CALC);
    cmd.div_start = (state_r == ST_CMP) && sts.notch_ok;
    cmd.apply     = (state_r == ST_CMP) && !sts.notch_ok;
    cmd.apply_div = (state_r == ST_DIV) && sts.div_done;
    cmd.dist_go   = (state_r == ST_DIST);
  end

  assign in_ready  = in_ready_r;
  assign out_valid = out_valid_r;

endmodule

### sv/dual_wheel_encoder_speed.sv
// top level of the dual wheel encoder speed tracker
`timescale 1ns / 1ps

// Tracks notch counts, distances and period-based speeds of two wheels. Every
// accepted item gives exactly one result with both counts, both distances
// (count * notch size, Q8 cm) and both speeds (Q8 cm/s). Items are handled one
// at a time: a counted notch passes through the 36-step radix-2 divider that
// forms notch_size*1e6/dt before out_valid; every other item skips the
// divider. in_ready returns the cycle after the result is taken.
// Write configuration only while no item is in flight.
module dual_wheel_encoder_speed
  import dwes_pkg::*;
#(
  parameter int SPEED_WIDTH = 24
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_we,
  input  logic                   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [1:0]             in_req_type,
  input  logic                   in_wheel,
  input  logic [TIME_W-1:0]      in_timestamp_us,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [COUNT_W-1:0]     out_left_count,
  output logic [COUNT_W-1:0]     out_right_count,
  output logic [DIST_W-1:0]      out_left_distance_q8,
  output logic [DIST_W-1:0]      out_right_distance_q8,
  output logic [SPEED_OUT_W-1:0] out_left_speed_q8,
  output logic [SPEED_OUT_W-1:0] out_right_speed_q8
);

  dwes_cmd_t cmd;
  dwes_sts_t sts;

  dwes_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  dwes_dp #(
    .SPEED_WIDTH (SPEED_WIDTH)
  ) u_dp (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .cmd                   (cmd),
    .sts                   (sts),
    .cfg_we                (cfg_we),
    .cfg_index             (cfg_index),
    .cfg_wdata             (cfg_wdata),
    .in_req_type           (in_req_type),
    .in_wheel              (in_wheel),
    .in_timestamp_us       (in_timestamp_us),
    .out_left_count        (out_left_count),
    .out_right_count       (out_right_count),
    .out_left_distance_q8  (out_left_distance_q8),
    .out_right_distance_q8 (out_right_distance_q8),
    .out_left_speed_q8     (out_left_speed_q8),
    .out_right_speed_q8    (out_right_speed_q8)
  );

endmodule

### sv/dwes_chk.sv
// port-level checks for the dual wheel encoder speed tracker
`timescale 1ns / 1ps

module dwes_chk
  import dwes_pkg::*;
(
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_valid,
  input logic                   in_ready,
  input logic                   out_valid,
  input logic                   out_ready,
  input logic [COUNT_W-1:0]     out_left_count,
  input logic [COUNT_W-1:0]     out_right_count,
  input logic [DIST_W-1:0]      out_left_distance_q8,
  input logic [DIST_W-1:0]      out_right_distance_q8,
  input logic [SPEED_OUT_W-1:0] out_left_speed_q8,
  input logic [SPEED_OUT_W-1:0] out_right_speed_q8
);

  // one item in flight: never ready for input while a result is shown
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid))
    else $error("input ready while result pending");

  a_no_instant_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !out_valid)
    else $error("result shown right after item accepted");

  a_dist_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_left_count == '0 || out_right_count == '0)) |->
    ((out_left_count != '0 || out_left_distance_q8 == '0) &&
     (out_right_count != '0 || out_right_distance_q8 == '0)))
    else $error("nonzero distance with zero count");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=>
    (out_valid && $stable(out_left_count) && $stable(out_right_count) &&
     $stable(out_left_speed_q8) && $stable(out_right_speed_q8)))
    else $error("stalled result changed");

endmodule

bind dual_wheel_encoder_speed dwes_chk u_dwes_chk (.*);

### tb/dual_wheel_encoder_speed_tb.sv
// testbench for the dual wheel encoder speed tracker: random and directed items, scoreboard check
`timescale 1ns / 1ps

module dual_wheel_encoder_speed_tb;
  import dwes_pkg::*;

  localparam logic [1:0] REQ_UNUSED  = 2'd3;
  localparam logic       WHEEL_LEFT  = 1'b0;
  localparam logic       WHEEL_RIGHT = 1'b1;
  localparam int         NUM_FIELDS  = 6;
  localparam int         NUM_PHASES  = 9;
  localparam int         PHASE_ITEMS = 220;
  localparam logic [SPEED_OUT_W-1:0] SPEED_SAT = '1;

  typedef struct packed {
    logic [COUNT_W-1:0]     left_count;
    logic [COUNT_W-1:0]     right_count;
    logic [DIST_W-1:0]      left_distance;
    logic [DIST_W-1:0]      right_distance;
    logic [SPEED_OUT_W-1:0] left_speed;
    logic [SPEED_OUT_W-1:0] right_speed;
  } reading_t;

  class odometry_scoreboard;
    logic [NOTCH_W-1:0]     notch_size;
    logic [TIMEOUT_W-1:0]   timeout;
    logic [COUNT_W-1:0]     notches [2];
    logic [TIME_W-1:0]      last_seen [2];
    logic [SPEED_OUT_W-1:0] speed [2];
    reading_t               pending_readings [$];
    int                     errors;

    function new();
      notch_size = NOTCH_RST;
      timeout    = TIMEOUT_RST;
      for (int w = 0; w < 2; w++) begin
        notches[w]   = '0;
        last_seen[w] = '0;
        speed[w]     = '0;
      end
      errors = 0;
    endfunction

    function void write_reg(logic idx, logic [CFG_DATA_W-1:0] data);
      if (idx == CFG_NOTCH_SIZE) notch_size = data[NOTCH_W-1:0];
      else timeout = data[TIMEOUT_W-1:0];
    endfunction

    function void count_notch(int w, logic [TIME_W-1:0] now);
      logic [TIME_W-1:0] dt;
      logic [63:0]       quot;
      dt = now - last_seen[w];
      if (dt != 0 && dt < 64'(timeout)) begin
        quot       = (64'(notch_size) * 64'(US_PER_S)) / dt;
        notches[w] = notches[w] + COUNT_W'(1);
        speed[w]   = (quot > 64'(SPEED_SAT)) ? SPEED_SAT : quot[SPEED_OUT_W-1:0];
      end else begin
        speed[w] = '0;
      end
      last_seen[w] = now;
    endfunction

    // predicts the reading for one accepted item and queues it
    function void note_item(logic [1:0] req, logic wheel, logic [TIME_W-1:0] now);
      reading_t r;
      case (req)
        REQ_NOTCH: count_notch(int'(wheel), now);
        REQ_CHECK: begin
          for (int w = 0; w < 2; w++)
            if (now - last_seen[w] > 64'(timeout)) speed[w] = '0;
        end
        REQ_CLEAR: begin
          for (int w = 0; w < 2; w++) begin
            notches[w]   = '0;
            last_seen[w] = now;
          end
        end
        default: ;
      endcase
      r.left_count     = notches[0];
      r.right_count    = notches[1];
      r.left_distance  = DIST_W'(64'(notches[0]) * 64'(notch_size));
      r.right_distance = DIST_W'(64'(notches[1]) * 64'(notch_size));
      r.left_speed     = speed[0];
      r.right_speed    = speed[1];
      pending_readings.push_back(r);
    endfunction

    function void check_result(reading_t got);
      reading_t    want;
      logic [63:0] want_f [NUM_FIELDS];
      logic [63:0] got_f [NUM_FIELDS];
      string       field_name [NUM_FIELDS];
      if (pending_readings.size() == 0) begin
        $display("%0t: unexpected reading %p", $time, got);
        errors++;
        return;
      end
      want = pending_readings.pop_front();
      field_name = '{"left_count", "right_count", "left_distance_q8", "right_distance_q8",
                     "left_speed_q8", "right_speed_q8"};
      want_f = '{64'(want.left_count), 64'(want.right_count), 64'(want.left_distance),
                 64'(want.right_distance), 64'(want.left_speed), 64'(want.right_speed)};
      got_f  = '{64'(got.left_count), 64'(got.right_count), 64'(got.left_distance),
                 64'(got.right_distance), 64'(got.left_speed), 64'(got.right_speed)};
      for (int i = 0; i < NUM_FIELDS; i++) begin
        if (want_f[i] !== got_f[i]) begin
          $display("%0t: %s expected %0d actual %0d", $time, field_name[i], want_f[i],
                   got_f[i]);
          errors++;
        end
      end
    endfunction
  endclass

  logic                   clk = 1'b0;
  logic                   rst_n;
  logic                   cfg_we;
  logic                   cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_wdata;
  logic                   in_valid;
  logic                   in_ready;
  logic [1:0]             in_req_type;
  logic                   in_wheel;
  logic [TIME_W-1:0]      in_timestamp_us;
  logic                   out_valid;
  logic                   out_ready;
  logic [COUNT_W-1:0]     out_left_count;
  logic [COUNT_W-1:0]     out_right_count;
  logic [DIST_W-1:0]      out_left_distance_q8;
  logic [DIST_W-1:0]      out_right_distance_q8;
  logic [SPEED_OUT_W-1:0] out_left_speed_q8;
  logic [SPEED_OUT_W-1:0] out_right_speed_q8;

  odometry_scoreboard     odo;
  bit                     no_idle = 1'b0;
  logic [TIMEOUT_W-1:0]   cur_timeout;
  logic [TIME_W-1:0]      now_us;
  logic [TIME_W-1:0]      stim_last [2];

  dual_wheel_encoder_speed u_dut (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .cfg_we                (cfg_we),
    .cfg_index             (cfg_index),
    .cfg_wdata             (cfg_wdata),
    .in_valid              (in_valid),
    .in_ready              (in_ready),
    .in_req_type           (in_req_type),
    .in_wheel              (in_wheel),
    .in_timestamp_us       (in_timestamp_us),
    .out_valid             (out_valid),
    .out_ready             (out_ready),
    .out_left_count        (out_left_count),
    .out_right_count       (out_right_count),
    .out_left_distance_q8  (out_left_distance_q8),
    .out_right_distance_q8 (out_right_distance_q8),
    .out_left_speed_q8     (out_left_speed_q8),
    .out_right_speed_q8    (out_right_speed_q8)
  );

  always #5 clk = ~clk;

  // everything is sampled at the edge, before the block's registers move
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_we) odo.write_reg(cfg_index, cfg_wdata);
      if (in_valid && in_ready) odo.note_item(in_req_type, in_wheel, in_timestamp_us);
      if (out_valid && out_ready)
        odo.check_result('{out_left_count, out_right_count, out_left_distance_q8,
                           out_right_distance_q8, out_left_speed_q8, out_right_speed_q8});
    end
  end

  function automatic int pick_gap();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic send_item(logic [1:0] req, logic wheel, logic [TIME_W-1:0] ts);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_req_type     <= req;
    in_wheel        <= wheel;
    in_timestamp_us <= ts;
    do @(posedge clk); while (!in_ready);
  endtask

  // keeps the stimulus side's own view of the wheel times for aiming at the timeout
  task automatic issue_item(logic [1:0] req, logic wheel, logic [TIME_W-1:0] ts);
    now_us = ts;
    if (req == REQ_NOTCH) stim_last[wheel] = ts;
    if (req == REQ_CLEAR) begin
      stim_last[0] = ts;
      stim_last[1] = ts;
    end
    send_item(req, wheel, ts);
  endtask

  // one edge first so the last accepted item is surely in the queue
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (odo.pending_readings.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic configure(logic [NOTCH_W-1:0] notch, logic [TIMEOUT_W-1:0] tmo);
    cur_timeout = tmo;
    cfg_we    <= 1'b1;
    cfg_index <= CFG_NOTCH_SIZE;
    // upper data bits are don't care for the notch size
    cfg_wdata <= CFG_DATA_W'({$urandom, notch});
    @(posedge clk);
    cfg_index <= CFG_TIMEOUT;
    cfg_wdata <= tmo;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic drive_random_traffic(int n);
    int               r;
    logic [1:0]       req;
    logic             wheel;
    logic [TIME_W-1:0] ts;
    repeat (n) begin
      r = $urandom_range(0, 99);
      req = (r < 78) ? REQ_NOTCH : (r < 90) ? REQ_CHECK : (r < 97) ? REQ_CLEAR : REQ_UNUSED;
      wheel = $urandom_range(0, 1);
      r = $urandom_range(0, 99);
      if (r < 4) ts = now_us;
      else if (r < 50) ts = now_us + 64'($urandom_range(1, 5000));
      else if (r < 75) ts = now_us + 64'($urandom_range(1, 300000));
      else if (r < 85) ts = now_us + 64'($urandom);
      // land right on the timeout boundary of one wheel
      else if (r < 94) ts = stim_last[wheel] + 64'(cur_timeout) + 64'($urandom_range(0, 2)) - 1;
      else if (r < 97) ts = {$urandom, $urandom};
      else ts = now_us - 64'($urandom_range(1, 1000));
      issue_item(req, wheel, ts);
    end
  endtask

  initial begin
    out_ready <= 1'b1;
    forever begin
      int stall;
      repeat ($urandom_range(1, 30)) @(posedge clk);
      stall = pick_gap();
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
        out_ready <= 1'b1;
      end
    end
  end

  initial begin
    logic [NOTCH_W-1:0]   notch_cfg [NUM_PHASES];
    logic [TIMEOUT_W-1:0] tmo_cfg [NUM_PHASES];
    odo = new();
    now_us       = '0;
    stim_last[0] = '0;
    stim_last[1] = '0;
    rst_n           <= 1'b0;
    cfg_we          <= 1'b0;
    cfg_index       <= CFG_NOTCH_SIZE;
    cfg_wdata       <= '0;
    in_valid        <= 1'b0;
    in_req_type     <= REQ_NOTCH;
    in_wheel        <= WHEEL_LEFT;
    in_timestamp_us <= '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    configure(NOTCH_RST, TIMEOUT_RST);

    issue_item(REQ_NOTCH, WHEEL_LEFT, 64'd0);            // zero interval
    issue_item(REQ_NOTCH, WHEEL_LEFT, 64'd1000);
    issue_item(REQ_NOTCH, WHEEL_RIGHT, 64'd1);           // saturated speed
    issue_item(REQ_CHECK, WHEEL_LEFT, 64'd2000);
    issue_item(REQ_CHECK, WHEEL_RIGHT, 64'd1501000);     // left idle exactly at timeout
    issue_item(REQ_CHECK, WHEEL_LEFT, 64'd1501001);
    issue_item(REQ_NOTCH, WHEEL_LEFT, 64'd1501000);      // interval equal to timeout
    issue_item(REQ_NOTCH, WHEEL_LEFT, 64'd3000999);      // one below timeout
    issue_item(REQ_NOTCH, WHEEL_RIGHT, '1);
    issue_item(REQ_NOTCH, WHEEL_RIGHT, 64'd5);           // wrapped time
    issue_item(REQ_UNUSED, WHEEL_RIGHT, {$urandom, $urandom});
    issue_item(REQ_CLEAR, WHEEL_RIGHT, 64'hFFFF_FFFF_FFFF_FFF0);
    issue_item(REQ_NOTCH, WHEEL_LEFT, 64'h10);
    issue_item(REQ_NOTCH, WHEEL_RIGHT, 64'h10);
    issue_item(REQ_NOTCH, WHEEL_RIGHT, 64'h10);
    issue_item(REQ_CLEAR, WHEEL_LEFT, 64'hAAAA_AAAA_5555_5555);
    issue_item(REQ_CHECK, WHEEL_RIGHT, 64'h5555_5555_AAAA_AAAA);
    issue_item(REQ_UNUSED, WHEEL_LEFT, 64'd0);

    notch_cfg = '{16'hFFFF, 16'd1, 16'd0, 16'd0, NOTCH_RST, 16'($urandom), 16'($urandom),
                  16'($urandom_range(1, 4000)), 16'($urandom)};
    tmo_cfg   = '{32'hFFFF_FFFF, 32'd1, 32'd0, TIMEOUT_RST, TIMEOUT_RST,
                  32'($urandom_range(1000, 4000000)), 32'($urandom_range(1000, 4000000)),
                  32'($urandom_range(100, 20000)), 32'($urandom)};
    for (int p = 0; p < NUM_PHASES; p++) begin
      wait_idle();
      configure(notch_cfg[p], tmo_cfg[p]);
      no_idle = (p == 4);
      drive_random_traffic(PHASE_ITEMS);
    end
    no_idle = 1'b0;
    wait_idle();
    repeat (60) @(posedge clk);
    if (odo.errors == 0 && odo.pending_readings.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule

### sim.f
sv/dwes_pkg.sv
sv/dwes_div.sv
sv/dwes_dp.sv
sv/dwes_ctrl.sv
sv/dual_wheel_encoder_speed.sv
sv/dwes_chk.sv
tb/dual_wheel_encoder_speed_tb.sv
